// ----- src/vna_pkg.sv -----
// shared constants, codes and transaction types of the vertex normal averager
// depends on nothing; every other file but vna_ram refers to it by scoped names
`timescale 1ns / 1ps

package vna_pkg;

    // defaults of the top level parameters
    localparam int MAX_VERTICES_DEF = 1024;
    localparam int SUM_BITS_DEF     = 24;

    // fixed field widths
    localparam int IDX_W   = 10;
    localparam int POS_W   = 32;
    localparam int NORM_W  = 16;
    localparam int WIDE_W  = 64;

    // depth of the command queue between front and back
    localparam int CMD_DEPTH = 4;

    // input mode codes
    localparam logic [1:0] MODE_STORE = 2'd0;
    localparam logic [1:0] MODE_FACE  = 2'd1;
    localparam logic [1:0] MODE_READ  = 2'd2;
    localparam logic [1:0] MODE_CLEAR = 2'd3;

    // classified operation codes
    localparam logic [2:0] OP_STORE = 3'd0;
    localparam logic [2:0] OP_FACE  = 3'd1;
    localparam logic [2:0] OP_READ  = 3'd2;
    localparam logic [2:0] OP_RZERO = 3'd3;
    localparam logic [2:0] OP_CLEAR = 3'd4;

    typedef logic signed [WIDE_W-1:0] wide_t;
    typedef logic signed [NORM_W-1:0] norm_t;

    // classified command handed from front to back
    typedef struct packed {
        logic [2:0]             op;
        logic [IDX_W-1:0]       idx;
        logic [3*POS_W-1:0]     pos;
        logic [IDX_W-1:0]       corner_a;
        logic [IDX_W-1:0]       corner_b;
        logic [IDX_W-1:0]       corner_c;
    } cmd_t;

    // control from back to front
    typedef struct packed {
        logic pop;
        logic init_busy;
    } back_ctl_t;

endpackage

// ----- src/vertex_normal_averager.sv -----
// per-vertex normal averaging: every accepted transaction but a store or face with an index
// out of range queues one command, and the back end runs the commands one at a time
// (throughput: one command per back end occupancy). a face or in-range read keeps the back
// end busy while the normalizer runs (1 bit of scaling, 1 root bit and 1 quotient bit per
// cycle); a read shows empty low once its result is in the output register, which waits
// for the previous result to be popped. after reset full stays high for a sweep that zeroes
// the accumulator ram. depends on vna_pkg, vna_front, vna_back
`timescale 1ns / 1ps

module vertex_normal_averager #(
    parameter int MAX_VERTICES = vna_pkg::MAX_VERTICES_DEF,
    parameter int SUM_BITS     = vna_pkg::SUM_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic [1:0]                  mode,
    input  logic [vna_pkg::IDX_W-1:0]   vertex_index,
    input  logic signed [31:0]          pos_x,
    input  logic signed [31:0]          pos_y,
    input  logic signed [31:0]          pos_z,
    input  logic [vna_pkg::IDX_W-1:0]   corner_a,
    input  logic [vna_pkg::IDX_W-1:0]   corner_b,
    input  logic [vna_pkg::IDX_W-1:0]   corner_c,
    output logic                        empty,
    input  logic                        pop,
    output logic signed [15:0]          norm_x,
    output logic signed [15:0]          norm_y,
    output logic signed [15:0]          norm_z
);

    logic               cmd_valid;
    vna_pkg::cmd_t      cmd;
    vna_pkg::back_ctl_t ctl;

    // accept and classify
    vna_front #(
        .MAX_VERTICES(MAX_VERTICES)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .mode         (mode),
        .vertex_index (vertex_index),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .pos_z        (pos_z),
        .corner_a     (corner_a),
        .corner_b     (corner_b),
        .corner_c     (corner_c),
        .cmd_valid    (cmd_valid),
        .cmd          (cmd),
        .ctl          (ctl)
    );

    // execute
    vna_back #(
        .MAX_VERTICES(MAX_VERTICES),
        .SUM_BITS(SUM_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .ctl       (ctl),
        .empty     (empty),
        .pop       (pop),
        .norm_x    (norm_x),
        .norm_y    (norm_y),
        .norm_z    (norm_z)
    );

endmodule

// ----- src/vna_ram.sv -----
// generic simple dual port ram, one write and one registered read per cycle
// depends on nothing
`timescale 1ns / 1ps

module vna_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// ----- src/vna_front.sv -----
// front part: accepts input transactions, classifies them and queues commands
// depends on vna_pkg
`timescale 1ns / 1ps

module vna_front #(
    parameter int MAX_VERTICES = vna_pkg::MAX_VERTICES_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic [1:0]                  mode,
    input  logic [vna_pkg::IDX_W-1:0]   vertex_index,
    input  logic [vna_pkg::POS_W-1:0]   pos_x,
    input  logic [vna_pkg::POS_W-1:0]   pos_y,
    input  logic [vna_pkg::POS_W-1:0]   pos_z,
    input  logic [vna_pkg::IDX_W-1:0]   corner_a,
    input  logic [vna_pkg::IDX_W-1:0]   corner_b,
    input  logic [vna_pkg::IDX_W-1:0]   corner_c,
    output logic                        cmd_valid,
    output vna_pkg::cmd_t               cmd,
    input  vna_pkg::back_ctl_t          ctl
);

    localparam int DEPTH = vna_pkg::CMD_DEPTH;
    localparam int PW    = $clog2(DEPTH);

    vna_pkg::cmd_t  q_mem [DEPTH];
    logic [PW-1:0]  wr_ptr_reg;
    logic [PW-1:0]  rd_ptr_reg;
    logic [PW:0]    count_reg;

    vna_pkg::cmd_t  cls;
    logic           keep;
    logic           enq;
    logic           deq;
    logic           ok_idx;
    logic           ok_a;
    logic           ok_b;
    logic           ok_c;

    // index range checks
    assign ok_idx = {22'd0, vertex_index} < 32'(MAX_VERTICES);
    assign ok_a   = {22'd0, corner_a} < 32'(MAX_VERTICES);
    assign ok_b   = {22'd0, corner_b} < 32'(MAX_VERTICES);
    assign ok_c   = {22'd0, corner_c} < 32'(MAX_VERTICES);

    // classify the incoming transaction
    always_comb
    begin
        cls.idx      = vertex_index;
        cls.pos      = {pos_z, pos_y, pos_x};
        cls.corner_a = corner_a;
        cls.corner_b = corner_b;
        cls.corner_c = corner_c;
        cls.op       = vna_pkg::OP_STORE;
        keep         = 1'b0;
        case (mode)
            vna_pkg::MODE_STORE:
            begin
                cls.op = vna_pkg::OP_STORE;
                keep   = ok_idx;
            end
            vna_pkg::MODE_FACE:
            begin
                cls.op = vna_pkg::OP_FACE;
                keep   = ok_a && ok_b && ok_c;
            end
            vna_pkg::MODE_READ:
            begin
                cls.op = ok_idx ? vna_pkg::OP_READ : vna_pkg::OP_RZERO;
                keep   = 1'b1;
            end
            vna_pkg::MODE_CLEAR:
            begin
                cls.op = vna_pkg::OP_CLEAR;
                keep   = 1'b1;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    // queue handshakes
    assign full      = (count_reg == (PW+1)'(DEPTH)) || ctl.init_busy;
    assign enq       = push && !full && keep;
    assign cmd_valid = count_reg != '0;
    assign deq       = ctl.pop && cmd_valid;
    assign cmd       = q_mem[rd_ptr_reg];

    // queue storage
    always_ff @(posedge clk)
    begin
        if (enq)
        begin
            q_mem[wr_ptr_reg] <= cls;
        end
    end

    // queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (enq)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (deq)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (enq && !deq)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (deq && !enq)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // queue never overfills
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (PW+1)'(DEPTH))
        else $error("command queue overfilled");

    // nothing enters during the power-up clearing sweep
    a_no_enq_init: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.init_busy |-> !enq)
        else $error("command queued during clearing sweep");

endmodule

// ----- src/vna_norm.sv -----
// normalizer: scales a vector, takes an iterative square root and divides
// each component to a q1.15 unit vector; depends on vna_pkg
`timescale 1ns / 1ps

module vna_norm (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  vna_pkg::wide_t  vin [3],
    output logic            done,
    output vna_pkg::norm_t  nout [3]
);

    localparam logic [2:0] N_IDLE = 3'd0;
    localparam logic [2:0] N_SCL  = 3'd1;
    localparam logic [2:0] N_SQ   = 3'd2;
    localparam logic [2:0] N_SRT  = 3'd3;
    localparam logic [2:0] N_DVI  = 3'd4;
    localparam logic [2:0] N_DIV  = 3'd5;
    localparam logic [2:0] N_OUT  = 3'd6;

    logic [2:0]  state_reg;
    logic [1:0]  k_reg;
    logic [4:0]  cnt_reg;

    logic [63:0] mag_reg [3];
    logic        neg_reg [3];
    logic [61:0] sq_reg;
    logic [63:0] x_reg;
    logic [63:0] res_reg;
    logic [63:0] bit_reg;
    logic [31:0] len_reg;
    logic [31:0] rem_reg [3];
    logic [16:0] nlo_reg [3];
    logic [16:0] q_reg [3];

    logic        any_hi;
    logic        any_30;
    logic        nz;
    logic        scl_done;
    logic [63:0] rb;
    logic        rb_ge;
    logic [46:0] nfull [3];
    logic [32:0] dt [3];
    logic        dge [3];
    logic [16:0] qs [3];

    // scaling status over the three magnitudes
    always_comb
    begin
        any_hi = 1'b0;
        any_30 = 1'b0;
        nz     = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            any_hi = any_hi | (|mag_reg[i][63:31]);
            any_30 = any_30 | (|mag_reg[i][63:30]);
            nz     = nz | (|mag_reg[i]);
        end
    end
    assign scl_done = !any_hi && !(nz && !any_30);

    // square root step
    assign rb    = res_reg + bit_reg;
    assign rb_ge = x_reg >= rb;

    // divider setup and step per lane
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            nfull[i] = {1'b0, mag_reg[i][30:0], 15'd0} + 47'(res_reg[31:1]);
            dt[i]    = {rem_reg[i], nlo_reg[i][16]};
            dge[i]   = dt[i] >= {1'b0, len_reg};
            qs[i]    = (q_reg[i] > 17'd32768) ? 17'd32768 : q_reg[i];
            if (neg_reg[i])
            begin
                nout[i] = vna_pkg::norm_t'(17'(-qs[i]));
            end
            else
            begin
                nout[i] = (qs[i] > 17'd32767) ? 16'sd32767 : vna_pkg::norm_t'(qs[i][15:0]);
            end
        end
    end

    assign done = state_reg == N_OUT;

    // sequencing
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= N_IDLE;
            k_reg     <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            case (state_reg)
                N_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= N_SCL;
                    end
                end
                N_SCL:
                begin
                    if (scl_done)
                    begin
                        state_reg <= N_SQ;
                        k_reg     <= '0;
                    end
                end
                N_SQ:
                begin
                    k_reg <= k_reg + 1'b1;
                    if (k_reg == 2'd3)
                    begin
                        state_reg <= N_SRT;
                    end
                end
                N_SRT:
                begin
                    if (bit_reg[0])
                    begin
                        state_reg <= N_DVI;
                    end
                end
                N_DVI:
                begin
                    cnt_reg   <= '0;
                    state_reg <= (res_reg == '0) ? N_OUT : N_DIV;
                end
                N_DIV:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == 5'd16)
                    begin
                        state_reg <= N_OUT;
                    end
                end
                N_OUT:
                begin
                    state_reg <= N_IDLE;
                end
                default:
                begin
                    state_reg <= N_IDLE;
                end
            endcase
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            N_IDLE:
            begin
                if (start)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        neg_reg[i] <= vin[i][63];
                        mag_reg[i] <= vin[i][63] ? 64'(-vin[i]) : 64'(vin[i]);
                    end
                end
            end
            N_SCL:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    if (any_hi)
                    begin
                        mag_reg[i] <= mag_reg[i] >> 1;
                    end
                    else if (nz && !any_30)
                    begin
                        mag_reg[i] <= mag_reg[i] << 1;
                    end
                end
            end
            N_SQ:
            begin
                if (k_reg != 2'd3)
                begin
                    sq_reg <= mag_reg[k_reg][30:0] * mag_reg[k_reg][30:0];
                end
                if (k_reg == 2'd0)
                begin
                    x_reg <= '0;
                end
                else
                begin
                    x_reg <= x_reg + {2'b00, sq_reg};
                end
                res_reg <= '0;
                bit_reg <= 64'd1 << 62;
            end
            N_SRT:
            begin
                if (rb_ge)
                begin
                    x_reg   <= x_reg - rb;
                    res_reg <= (res_reg >> 1) + bit_reg;
                end
                else
                begin
                    res_reg <= res_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
            end
            N_DVI:
            begin
                len_reg <= res_reg[31:0];
                for (int i = 0; i < 3; i++)
                begin
                    rem_reg[i] <= 32'(nfull[i][46:17]);
                    nlo_reg[i] <= nfull[i][16:0];
                    q_reg[i]   <= '0;
                end
            end
            N_DIV:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    nlo_reg[i] <= nlo_reg[i] << 1;
                    if (dge[i])
                    begin
                        rem_reg[i] <= 32'(dt[i] - {1'b0, len_reg});
                        q_reg[i]   <= {q_reg[i][15:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg[i] <= dt[i][31:0];
                        q_reg[i]   <= {q_reg[i][15:0], 1'b0};
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // a start only lands on an idle normalizer
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> state_reg == N_IDLE)
        else $error("normalizer started while busy");

    // completion is a single cycle pulse
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("normalizer done held");

endmodule

// ----- src/vna_back.sv -----
// back part: executes commands against the vertex and accumulator rams,
// forms face normals and holds the result register; depends on vna_pkg,
// vna_ram and vna_norm
`timescale 1ns / 1ps

module vna_back #(
    parameter int MAX_VERTICES = vna_pkg::MAX_VERTICES_DEF,
    parameter int SUM_BITS     = vna_pkg::SUM_BITS_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cmd_valid,
    input  vna_pkg::cmd_t           cmd,
    output vna_pkg::back_ctl_t      ctl,
    output logic                    empty,
    input  logic                    pop,
    output vna_pkg::norm_t          norm_x,
    output vna_pkg::norm_t          norm_y,
    output vna_pkg::norm_t          norm_z
);

    localparam int AW = $clog2(MAX_VERTICES);
    localparam int SB = SUM_BITS;
    localparam int VW = 3 * vna_pkg::POS_W;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_CLR  = 4'd1;
    localparam logic [3:0] S_FRA  = 4'd2;
    localparam logic [3:0] S_FRB  = 4'd3;
    localparam logic [3:0] S_FRC  = 4'd4;
    localparam logic [3:0] S_FCAP = 4'd5;
    localparam logic [3:0] S_FPRE = 4'd6;
    localparam logic [3:0] S_FMUL = 4'd7;
    localparam logic [3:0] S_FGO  = 4'd8;
    localparam logic [3:0] S_FNRM = 4'd9;
    localparam logic [3:0] S_URD  = 4'd10;
    localparam logic [3:0] S_UWR  = 4'd11;
    localparam logic [3:0] S_RRD  = 4'd12;
    localparam logic [3:0] S_RCAP = 4'd13;
    localparam logic [3:0] S_RNRM = 4'd14;
    localparam logic [3:0] S_OUT  = 4'd15;

    logic [3:0]     state_reg;
    logic           init_reg;
    logic [AW-1:0]  clr_cnt_reg;
    logic [2:0]     k_reg;
    logic [1:0]     u_reg;
    logic           out_valid_reg;

    logic [AW-1:0]  a_reg;
    logic [AW-1:0]  b_reg;
    logic [AW-1:0]  c_reg;
    logic [VW-1:0]  va_reg;
    logic [VW-1:0]  vb_reg;
    logic signed [32:0] d_reg [6];
    logic [30:0]    em_reg [6];
    logic           es_reg [6];
    logic [61:0]    prod_reg;
    logic           psn_reg;
    vna_pkg::wide_t cr_reg [3];
    vna_pkg::norm_t n_reg [3];
    vna_pkg::norm_t out_reg [3];

    // ram ports
    logic           v_we;
    logic [AW-1:0]  v_raddr;
    logic [VW-1:0]  v_rdata;
    logic           s_we;
    logic [AW-1:0]  s_waddr;
    logic [3*SB-1:0] s_wdata;
    logic [AW-1:0]  s_raddr;
    logic [3*SB-1:0] s_rdata;

    // normalizer ports
    logic           n_start;
    vna_pkg::wide_t n_vin [3];
    logic           n_done;
    vna_pkg::norm_t n_out [3];

    logic [AW-1:0]  corner;
    logic [32:0]    dm [6];
    logic           hi2;
    logic           hi1;
    logic [30:0]    op_l;
    logic [30:0]    op_r;
    logic           sn_l;
    logic           sn_r;
    vna_pkg::wide_t term;
    logic [1:0]     cr_sel;
    logic [3*SB-1:0] sat_sum;

    assign ctl.pop       = (state_reg == S_IDLE) && cmd_valid && !init_reg;
    assign ctl.init_busy = init_reg;
    assign empty         = !out_valid_reg;
    assign norm_x        = out_reg[0];
    assign norm_y        = out_reg[1];
    assign norm_z        = out_reg[2];

    // corner selected for the accumulator update
    always_comb
    begin
        case (u_reg)
            2'd0:    corner = a_reg;
            2'd1:    corner = b_reg;
            default: corner = c_reg;
        endcase
    end

    // vertex ram read address
    always_comb
    begin
        case (state_reg)
            S_FRB:   v_raddr = b_reg;
            S_FRC:   v_raddr = c_reg;
            default: v_raddr = a_reg;
        endcase
    end

    assign v_we    = ctl.pop && (cmd.op == vna_pkg::OP_STORE);
    assign s_we    = (state_reg == S_CLR) || (state_reg == S_UWR);
    assign s_waddr = (state_reg == S_CLR) ? clr_cnt_reg : corner;
    assign s_wdata = (state_reg == S_CLR) ? '0 : sat_sum;
    assign s_raddr = (state_reg == S_URD) ? corner : a_reg;

    vna_ram #(
        .WIDTH(VW),
        .DEPTH(MAX_VERTICES)
    ) u_vram (
        .clk   (clk),
        .we    (v_we),
        .waddr (AW'(cmd.idx)),
        .wdata (cmd.pos),
        .raddr (v_raddr),
        .rdata (v_rdata)
    );

    vna_ram #(
        .WIDTH(3 * SB),
        .DEPTH(MAX_VERTICES)
    ) u_sram (
        .clk   (clk),
        .we    (s_we),
        .waddr (s_waddr),
        .wdata (s_wdata),
        .raddr (s_raddr),
        .rdata (s_rdata)
    );

    // saturating accumulate of the current normal into one vertex
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            logic signed [SB:0] s;
            s = $signed({s_rdata[i*SB + SB-1], s_rdata[i*SB +: SB]})
                + (SB+1)'(n_reg[i]);
            if (s[SB] != s[SB-1])
            begin
                sat_sum[i*SB +: SB] = s[SB] ? {1'b1, {(SB-1){1'b0}}}
                                            : {1'b0, {(SB-1){1'b1}}};
            end
            else
            begin
                sat_sum[i*SB +: SB] = s[SB-1:0];
            end
        end
    end

    // edge magnitudes and common prescale
    always_comb
    begin
        hi2 = 1'b0;
        hi1 = 1'b0;
        for (int i = 0; i < 6; i++)
        begin
            dm[i] = d_reg[i][32] ? 33'(-d_reg[i]) : 33'(d_reg[i]);
            hi2   = hi2 | dm[i][32];
            hi1   = hi1 | dm[i][31];
        end
    end

    // cross product operand schedule
    always_comb
    begin
        case (k_reg)
            3'd0:    begin op_l = em_reg[1]; op_r = em_reg[5]; sn_l = es_reg[1]; sn_r = es_reg[5]; end
            3'd1:    begin op_l = em_reg[2]; op_r = em_reg[4]; sn_l = es_reg[2]; sn_r = es_reg[4]; end
            3'd2:    begin op_l = em_reg[2]; op_r = em_reg[3]; sn_l = es_reg[2]; sn_r = es_reg[3]; end
            3'd3:    begin op_l = em_reg[0]; op_r = em_reg[5]; sn_l = es_reg[0]; sn_r = es_reg[5]; end
            3'd4:    begin op_l = em_reg[0]; op_r = em_reg[4]; sn_l = es_reg[0]; sn_r = es_reg[4]; end
            default: begin op_l = em_reg[1]; op_r = em_reg[3]; sn_l = es_reg[1]; sn_r = es_reg[3]; end
        endcase
    end

    // previous product goes into its component, odd steps subtract
    always_comb
    begin
        logic [2:0] km1;
        km1    = k_reg - 3'd1;
        cr_sel = km1[2:1];
        term   = (psn_reg ^ km1[0]) ? -vna_pkg::wide_t'({2'b00, prod_reg})
                                    : vna_pkg::wide_t'({2'b00, prod_reg});
    end

    // normalizer input: face cross product or stored sums
    assign n_start = (state_reg == S_FGO) || (state_reg == S_RCAP);
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (state_reg == S_RCAP)
            begin
                n_vin[i] = vna_pkg::wide_t'($signed(s_rdata[i*SB +: SB]));
            end
            else
            begin
                n_vin[i] = cr_reg[i];
            end
        end
    end

    vna_norm u_norm (
        .clk   (clk),
        .rst_n (rst_n),
        .start (n_start),
        .vin   (n_vin),
        .done  (n_done),
        .nout  (n_out)
    );

    // command sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            init_reg      <= 1'b1;
            clr_cnt_reg   <= '0;
            k_reg         <= '0;
            u_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop && out_valid_reg)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (ctl.pop)
                    begin
                        case (cmd.op)
                            vna_pkg::OP_FACE:  state_reg <= S_FRA;
                            vna_pkg::OP_READ:  state_reg <= S_RRD;
                            vna_pkg::OP_RZERO: state_reg <= S_OUT;
                            vna_pkg::OP_CLEAR:
                            begin
                                clr_cnt_reg <= '0;
                                state_reg   <= S_CLR;
                            end
                            default:           state_reg <= S_IDLE;
                        endcase
                    end
                end
                S_CLR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    if (clr_cnt_reg == AW'(MAX_VERTICES - 1))
                    begin
                        init_reg  <= 1'b0;
                        state_reg <= S_IDLE;
                    end
                end
                S_FRA:  state_reg <= S_FRB;
                S_FRB:  state_reg <= S_FRC;
                S_FRC:  state_reg <= S_FCAP;
                S_FCAP: state_reg <= S_FPRE;
                S_FPRE:
                begin
                    k_reg     <= '0;
                    state_reg <= S_FMUL;
                end
                S_FMUL:
                begin
                    k_reg <= k_reg + 1'b1;
                    if (k_reg == 3'd6)
                    begin
                        state_reg <= S_FGO;
                    end
                end
                S_FGO:  state_reg <= S_FNRM;
                S_FNRM:
                begin
                    if (n_done)
                    begin
                        u_reg     <= '0;
                        state_reg <= S_URD;
                    end
                end
                S_URD:  state_reg <= S_UWR;
                S_UWR:
                begin
                    u_reg <= u_reg + 1'b1;
                    state_reg <= (u_reg == 2'd2) ? S_IDLE : S_URD;
                end
                S_RRD:  state_reg <= S_RCAP;
                S_RCAP: state_reg <= S_RNRM;
                S_RNRM:
                begin
                    if (n_done)
                    begin
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (!out_valid_reg)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                a_reg <= AW'(cmd.op == vna_pkg::OP_FACE ? cmd.corner_a : cmd.idx);
                b_reg <= AW'(cmd.corner_b);
                c_reg <= AW'(cmd.corner_c);
                for (int i = 0; i < 3; i++)
                begin
                    n_reg[i] <= '0;
                end
            end
            S_FRB:  va_reg <= v_rdata;
            S_FRC:  vb_reg <= v_rdata;
            S_FCAP:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    d_reg[i]     <= $signed({va_reg[32*i+31], va_reg[32*i +: 32]})
                                  - $signed({vb_reg[32*i+31], vb_reg[32*i +: 32]});
                    d_reg[3 + i] <= $signed({vb_reg[32*i+31], vb_reg[32*i +: 32]})
                                  - $signed({v_rdata[32*i+31], v_rdata[32*i +: 32]});
                end
            end
            S_FPRE:
            begin
                for (int i = 0; i < 6; i++)
                begin
                    es_reg[i] <= d_reg[i][32];
                    if (hi2)
                    begin
                        em_reg[i] <= dm[i][32:2];
                    end
                    else if (hi1)
                    begin
                        em_reg[i] <= dm[i][31:1];
                    end
                    else
                    begin
                        em_reg[i] <= dm[i][30:0];
                    end
                end
                for (int i = 0; i < 3; i++)
                begin
                    cr_reg[i] <= '0;
                end
            end
            S_FMUL:
            begin
                if (k_reg != 3'd6)
                begin
                    prod_reg <= op_l * op_r;
                    psn_reg  <= sn_l ^ sn_r;
                end
                if (k_reg != 3'd0)
                begin
                    cr_reg[cr_sel] <= cr_reg[cr_sel] + term;
                end
            end
            S_FNRM, S_RNRM:
            begin
                if (n_done)
                begin
                    n_reg <= n_out;
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg)
                begin
                    out_reg <= n_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    // commands are taken only by an idle sequencer
    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.pop |-> state_reg == S_IDLE)
        else $error("command taken while busy");

endmodule
